// ===== sv/idsc_pkg.sv =====
// ----------------------------------------------------------------------------
// idsc_pkg: shared types and constants for the include directive scanner
// Result codes, character constants, queue sizing and the result record.
// ----------------------------------------------------------------------------
package idsc_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [2:0] KEYWORD_LEN = 3'd7;

    // Result queue sizing
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
    // Input is held off above this fill level: one item in the input
    // register and one being accepted may each push two results.
    localparam int STALL_LEVEL = QUEUE_DEPTH - 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } idsc_result_t;

    typedef struct packed {
        logic [1:0]   num;
        idsc_result_t first;
        idsc_result_t second;
    } idsc_push_t;

    // Letters of "include" by position
    function automatic logic [7:0] keyword_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h69; // i
            3'd1:    c = 8'h6E; // n
            3'd2:    c = 8'h63; // c
            3'd3:    c = 8'h6C; // l
            3'd4:    c = 8'h75; // u
            3'd5:    c = 8'h64; // d
            3'd6:    c = 8'h65; // e
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
               (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
    endfunction

endpackage

// ===== sv/include_directive_scanner.sv =====
// ----------------------------------------------------------------------------
// include_directive_scanner: finds #include "name" directives in a byte stream
// Input register, parser state machine and a small result queue.
// ----------------------------------------------------------------------------
// The scanner takes one source byte per clock while in_stall is low, each
// with an end-of-buffer flag, and streams out the bytes of every #include
// "name" it finds, then a completion result at the closing quote or an abort
// result at a newline or the end of the buffer. Line and block comments
// outside directives are skipped. An accepted byte is parsed while it sits
// in the input register, and its results enter the queue at the next clock
// edge. A result is shown on the output when it reaches the queue head, and
// it is taken there when out_stall is low. The parser state register
// advances on every accepted byte. Each byte gives at most two results and
// the output hands over one per clock while out_stall is low, so a byte
// ending a buffer inside a name momentarily gives more results than the
// output can pass on; an eight-entry result queue absorbs that, and the
// input stalls only while more than four results wait in it.
// ----------------------------------------------------------------------------
module include_directive_scanner
    import idsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_buffer,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] result_kind,
    output logic [7:0] name_byte
);

    // input register
    logic       item_valid_reg;
    logic [7:0] item_byte_reg;
    logic       item_last_reg;

    logic                in_take;
    logic                out_take;
    idsc_push_t          push;
    idsc_result_t        head;
    logic [QCOUNT_W-1:0] q_count;

    // Hold the input off once the queue could not absorb the worst case of
    // the item already registered plus the one about to be taken.
    assign in_stall = (q_count > QCOUNT_W'(STALL_LEVEL));
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= in_take;
    end

    // payload captured on every accepted item
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_byte_reg <= data_byte;
            item_last_reg <= end_of_buffer;
        end
    end

    // parse the registered byte; results go straight into the queue
    idsc_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .item_byte  (item_byte_reg),
        .item_last  (item_last_reg),
        .push       (push)
    );

    // the queue head is the output register: it holds while stalled
    assign out_valid = (q_count != '0);
    assign out_take  = out_valid && !out_stall;

    idsc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (out_take),
        .head  (head),
        .count (q_count)
    );

    assign result_kind = head.kind;
    assign name_byte   = head.data;

endmodule

// ===== sv/idsc_fsm.sv =====
// ----------------------------------------------------------------------------
// idsc_fsm: directive parser state machine
// Advances the parse state on one registered byte and forms its results.
// ----------------------------------------------------------------------------
module idsc_fsm
    import idsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       item_last,
    output idsc_push_t push
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SLASH   = 4'd1,
        PH_LINE    = 4'd2,
        PH_BLOCK   = 4'd3,
        PH_HASH    = 4'd4,
        PH_KEYWORD = 4'd5,
        PH_AFTERKW = 4'd6,
        PH_NAME    = 4'd7
    } phase_t;

    phase_t     parse_phase_reg,      parse_phase_next;
    logic [2:0] keyword_position_reg, keyword_position_next;
    logic       star_before_reg,      star_before_next;

    phase_t     idle_phase;
    phase_t     step_phase;
    logic [2:0] kw_inc;

    always_comb
    begin
        if (item_byte == CH_HASH)
            idle_phase = PH_HASH;
        else if (item_byte == CH_SLASH)
            idle_phase = PH_SLASH;
        else
            idle_phase = PH_IDLE;
    end

    always_comb
    begin
        step_phase            = parse_phase_reg;
        keyword_position_next = keyword_position_reg;
        star_before_next      = star_before_reg;
        kw_inc                = keyword_position_reg + 3'd1;
        push                  = '0;

        case (parse_phase_reg)
            PH_SLASH:
            begin
                if (item_byte == CH_SLASH)
                    step_phase = PH_LINE;
                else if (item_byte == CH_STAR)
                begin
                    step_phase       = PH_BLOCK;
                    star_before_next = 1'b1;
                end
                else
                    step_phase = idle_phase;
            end
            PH_LINE:
            begin
                if (item_byte == CH_NEWLINE)
                    step_phase = PH_IDLE;
            end
            PH_BLOCK:
            begin
                // a slash right after a star closes, the opener's star included
                if (item_byte == CH_SLASH && star_before_reg)
                begin
                    step_phase       = PH_IDLE;
                    star_before_next = 1'b0;
                end
                else
                    star_before_next = (item_byte == CH_STAR);
            end
            PH_HASH:
            begin
                if (!is_blank(item_byte))
                begin
                    if (item_byte == keyword_char(3'd0))
                    begin
                        step_phase            = PH_KEYWORD;
                        keyword_position_next = 3'd1;
                    end
                    else
                        step_phase = PH_IDLE;
                end
            end
            PH_KEYWORD:
            begin
                if (keyword_position_reg < KEYWORD_LEN &&
                    item_byte == keyword_char(keyword_position_reg))
                begin
                    if (kw_inc == KEYWORD_LEN)
                    begin
                        step_phase            = PH_AFTERKW;
                        keyword_position_next = 3'd0;
                    end
                    else
                        keyword_position_next = kw_inc;
                end
                else
                begin
                    keyword_position_next = 3'd0;
                    step_phase            = idle_phase;
                end
            end
            PH_AFTERKW:
            begin
                if (!is_blank(item_byte))
                    step_phase = (item_byte == CH_QUOTE) ? PH_NAME : PH_IDLE;
            end
            PH_NAME:
            begin
                push.num = 2'd1;
                if (item_byte == CH_NEWLINE)
                begin
                    push.first = '{kind: KIND_ABORT, data: 8'h00};
                    step_phase = PH_IDLE;
                end
                else if (item_byte == CH_QUOTE)
                begin
                    push.first = '{kind: KIND_DONE, data: 8'h00};
                    step_phase = PH_IDLE;
                end
                else
                    push.first = '{kind: KIND_BYTE, data: item_byte};
            end
            default:
                step_phase = idle_phase;
        endcase

        parse_phase_next = step_phase;

        // buffer end: abort an open name, then drop back to reset values
        if (item_last)
        begin
            if (step_phase == PH_NAME)
            begin
                if (push.num == 2'd0)
                    push.first = '{kind: KIND_ABORT, data: 8'h00};
                else
                    push.second = '{kind: KIND_ABORT, data: 8'h00};
                push.num = push.num + 2'd1;
            end
            parse_phase_next      = PH_IDLE;
            keyword_position_next = 3'd0;
            star_before_next      = 1'b0;
        end

        if (!item_valid)
        begin
            push                  = '0;
            parse_phase_next      = parse_phase_reg;
            keyword_position_next = keyword_position_reg;
            star_before_next      = star_before_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase_reg      <= PH_IDLE;
            keyword_position_reg <= 3'd0;
            star_before_reg      <= 1'b0;
        end
        else
        begin
            parse_phase_reg      <= parse_phase_next;
            keyword_position_reg <= keyword_position_next;
            star_before_reg      <= star_before_next;
        end
    end

endmodule

// ===== sv/idsc_queue.sv =====
// ----------------------------------------------------------------------------
// idsc_queue: result queue
// Takes up to two results per cycle and hands out one per cycle on each pop.
// ----------------------------------------------------------------------------
module idsc_queue
    import idsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  idsc_push_t          push,
    input  logic                pop,
    output idsc_result_t        head,
    output logic [QCOUNT_W-1:0] count
);

    idsc_result_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      head_reg,  head_next;
    logic [PTR_W-1:0]      tail_reg,  tail_next;
    logic [QCOUNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        head_next  = pop ? head_reg + PTR_W'(1) : head_reg;
        tail_next  = tail_reg + PTR_W'(push.num);
        count_next = count_reg + QCOUNT_W'(push.num) - QCOUNT_W'(pop);
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
            entry_reg[tail_reg] <= push.first;
        if (push.num == 2'd2)
            entry_reg[tail_reg + PTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign head  = entry_reg[head_reg];
    assign count = count_reg;

endmodule

// ===== sv/idsc_checker.sv =====
// ----------------------------------------------------------------------------
// idsc_checker: port-level checks for the include directive scanner
// Watches the top-level ports and flags broken result or stall behavior.
// ----------------------------------------------------------------------------
module idsc_checker
    import idsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] data_byte,
    input logic       end_of_buffer,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] result_kind,
    input logic [7:0] name_byte
);

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(name_byte))
    else $error("stalled result changed or dropped");

    // only the three defined kinds appear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == KIND_BYTE || result_kind == KIND_DONE ||
                       result_kind == KIND_ABORT))
    else $error("undefined result kind");

    // completion and abort carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_BYTE |-> name_byte == 8'h00)
    else $error("nonzero byte on completion or abort");

    // input back-pressure only comes from results waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
    else $error("input stalled with no result pending");

    // a stalled input item is held by the sender
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(end_of_buffer))
    else $error("stalled input item changed or dropped");

endmodule

bind include_directive_scanner idsc_checker u_idsc_checker (.*);

// ===== dv/include_directive_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// include_directive_scanner_tb: self-checking bench for the include scanner
// A short stimulus table, then random directives, comments and noise, with
// random idling on both channels and one long output hold-off. Every item
// taken by the scanner runs through a byte-level model of the directive
// parser, and each result is compared in order with the expectation (typed rows override the model).
// ----------------------------------------------------------------------------
module include_directive_scanner_tb;
    import idsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One item of source text, with an optional typed-in expectation
    typedef struct packed {
        logic [7:0]   data;
        logic         eob;
        logic         typed;
        logic [1:0]   n_typed;
        idsc_result_t r0;
        idsc_result_t r1;
    } scan_row_t;

    // Parser phases of the model
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLASH_SEEN,
        ST_LINE_CMT,
        ST_BLOCK_CMT,
        ST_AFTER_HASH,
        ST_KEYWORD,
        ST_AFTER_KEYWORD,
        ST_NAME
    } scan_phase_t;

    localparam idsc_result_t NO_RESULT = '{KIND_BYTE, 8'h00};
    localparam logic [55:0] KW_TEXT = "include";
    localparam int RANDOM_ITEMS = 850;
    localparam int MAX_REPORTS = 10;

    // Directed part: the row expectation is typed in only where it is obvious
    localparam scan_row_t DIRECTED_ROWS [0:23] = '{
        '{CH_SLASH,   1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT}, // after reset
        '{CH_HASH,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT}, // hash after lone slash
        '{8'h09,      1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"i",        1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"n",        1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"c",        1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"l",        1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"u",        1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"d",        1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"e",        1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_QUOTE,   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{8'hFF,      1'b0, 1'b1, 2'd1, '{KIND_BYTE, 8'hFF}, NO_RESULT},
        '{8'h00,      1'b0, 1'b1, 2'd1, '{KIND_BYTE, 8'h00}, NO_RESULT},
        '{CH_QUOTE,   1'b0, 1'b1, 2'd1, '{KIND_DONE, 8'h00}, NO_RESULT},
        '{CH_HASH,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"x",        1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT}, // wrong first letter
        '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_STAR,    1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT}, // slash-star-slash closes
        '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
        '{"a",        1'b1, 1'b0, 2'd0, NO_RESULT, NO_RESULT}, // line comment hits end
        '{CH_SLASH,   1'b1, 1'b0, 2'd0, NO_RESULT, NO_RESULT}, // slash as last byte
        '{8'hFF,      1'b1, 1'b1, 2'd0, NO_RESULT, NO_RESULT}
    };

    // DUT ports; the inputs are known from time zero
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_buffer = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] result_kind;
    logic [7:0] name_byte;

    // Model state
    scan_phase_t phase_q = ST_IDLE;
    logic [2:0]  kw_pos = 3'd0;
    logic        star_seen = 1'b0;

    scan_row_t    source_bytes [$];
    idsc_result_t name_results_due [$];
    scan_row_t    cur_row;
    int           counted_bytes = 0;
    int           taken_bytes = 0;
    int           errors = 0;
    bit           long_hold = 1'b0;

    include_directive_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .name_byte     (name_byte)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the parser
    // ------------------------------------------------------------------------
    function automatic logic [7:0] kw_letter(input int pos);
        return KW_TEXT[(6 - pos) * 8 +: 8];
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        case (b)
            8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
            default:                                 return 1'b0;
        endcase
    endfunction

    // Phase for a byte seen outside any construct
    function automatic scan_phase_t phase_from_idle(input logic [7:0] b);
        if (b == CH_HASH)
            return ST_AFTER_HASH;
        if (b == CH_SLASH)
            return ST_SLASH_SEEN;
        return ST_IDLE;
    endfunction

    // Advance the model by one byte; return how many results it causes
    function automatic int scan_byte(input logic [7:0] b, input logic last,
                                     output idsc_result_t r0, output idsc_result_t r1);
        int n;
        n = 0;
        r0 = NO_RESULT;
        r1 = NO_RESULT;
        case (phase_q)
            ST_SLASH_SEEN:
            begin
                if (b == CH_SLASH)
                    phase_q = ST_LINE_CMT;
                else if (b == CH_STAR)
                begin
                    phase_q = ST_BLOCK_CMT;
                    star_seen = 1'b1;   // the opener's star counts
                end
                else
                    phase_q = phase_from_idle(b);
            end
            ST_LINE_CMT:
            begin
                if (b == CH_NEWLINE)
                    phase_q = ST_IDLE;
            end
            ST_BLOCK_CMT:
            begin
                if (b == CH_SLASH && star_seen)
                begin
                    phase_q = ST_IDLE;
                    star_seen = 1'b0;
                end
                else
                    star_seen = (b == CH_STAR);
            end
            ST_AFTER_HASH:
            begin
                if (!is_space(b))
                begin
                    if (b == kw_letter(0))
                    begin
                        phase_q = ST_KEYWORD;
                        kw_pos = 3'd1;
                    end
                    else
                        phase_q = ST_IDLE;
                end
            end
            ST_KEYWORD:
            begin
                if (kw_pos < 3'd7 && b == kw_letter(int'(kw_pos)))
                begin
                    kw_pos = kw_pos + 3'd1;
                    if (kw_pos == 3'd7)
                    begin
                        phase_q = ST_AFTER_KEYWORD;
                        kw_pos = 3'd0;
                    end
                end
                else
                begin
                    kw_pos = 3'd0;
                    phase_q = phase_from_idle(b);
                end
            end
            ST_AFTER_KEYWORD:
            begin
                if (!is_space(b))
                    phase_q = (b == CH_QUOTE) ? ST_NAME : ST_IDLE;
            end
            ST_NAME:
            begin
                n = 1;
                if (b == CH_NEWLINE)
                begin
                    r0 = '{KIND_ABORT, 8'h00};
                    phase_q = ST_IDLE;
                end
                else if (b == CH_QUOTE)
                begin
                    r0 = '{KIND_DONE, 8'h00};
                    phase_q = ST_IDLE;
                end
                else
                    r0 = '{KIND_BYTE, b};
            end
            default:
                phase_q = phase_from_idle(b);
        endcase

        // Buffer end: abort an open name, then drop all state
        if (last)
        begin
            if (phase_q == ST_NAME)
            begin
                if (n == 0)
                    r0 = '{KIND_ABORT, 8'h00};
                else
                    r1 = '{KIND_ABORT, 8'h00};
                n++;
            end
            phase_q = ST_IDLE;
            kw_pos = 3'd0;
            star_seen = 1'b0;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    // Queue one random item; a rare random buffer end is mixed in everywhere
    task automatic push_byte(input logic [7:0] b, input logic eob, input bit counts = 1'b1);
        scan_row_t row;
        row = '{b, eob | ($urandom_range(0, 59) == 0), 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        source_bytes.push_back(row);
        if (counts)
            counted_bytes++;
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0A;
            3:       return 8'h0B;
            4:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    task automatic add_blanks();
        int n;
        n = $urandom_range(0, 2);
        repeat (n) push_byte(pick_blank(), 1'b0);
    endtask

    // Any byte except the ones that end a name
    function automatic logic [7:0] pick_name_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_NEWLINE)
            b = b ^ 8'h40;
        return b;
    endfunction

    // Append one random construct: mostly whole directives with random names
    task automatic add_segment();
        int pick;
        int len;
        int term;
        int i;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            push_byte(CH_HASH, 1'b0);
            add_blanks();
            for (i = 0; i < 7; i++)
                push_byte(kw_letter(i), 1'b0);
            add_blanks();
            len = $urandom_range(0, 8);
            term = $urandom_range(0, 4);
            // term 3 ends the buffer inside the name, term 4 leaves it open
            push_byte(CH_QUOTE, term == 3 && len == 0);
            for (i = 0; i < len; i++)
                push_byte(pick_name_char(), term == 3 && i == len - 1);
            if (term <= 1)
                push_byte(CH_QUOTE, 1'b0);
            else if (term == 2)
                push_byte(CH_NEWLINE, 1'b0);
        end
        else if (pick < 65)
        begin
            // Broken directive: keyword cut short, or junk after it
            push_byte(CH_HASH, 1'b0);
            add_blanks();
            len = $urandom_range(0, 7);
            for (i = 0; i < len; i++)
                push_byte(kw_letter(i), 1'b0);
            if (len == 7)
                add_blanks();
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (pick < 75)
        begin
            push_byte(CH_SLASH, 1'b0);
            push_byte(CH_SLASH, 1'b0);
            len = $urandom_range(0, 6);
            repeat (len) push_byte(8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 1) == 0)
                push_byte(CH_NEWLINE, 1'b0);
            else
                push_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        else if (pick < 85)
        begin
            push_byte(CH_SLASH, 1'b0);
            push_byte(CH_STAR, 1'b0);
            len = $urandom_range(0, 8);
            for (i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 2))
                    0:       push_byte(CH_STAR, 1'b0);
                    1:       push_byte(CH_SLASH, 1'b0);
                    default: push_byte(8'($urandom_range(0, 255)), 1'b0);
                endcase
            end
            push_byte(CH_STAR, 1'b0);
            push_byte(CH_SLASH, 1'b0);
        end
        else
        begin
            // Noise; a leading slash gives the lone-slash paths a chance
            if ($urandom_range(0, 1) == 0)
                push_byte(CH_SLASH, 1'b0, 1'b0);
            len = $urandom_range(1, 6);
            repeat (len) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side: predict every item the scanner takes
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        idsc_result_t r0;
        idsc_result_t r1;
        int n;
        if (rst_n && in_valid && !in_stall)
        begin
            taken_bytes++;
            n = scan_byte(cur_row.data, cur_row.eob, r0, r1);
            // Typed rows stand in for the model's answer
            if (cur_row.typed)
            begin
                n = int'(cur_row.n_typed);
                r0 = cur_row.r0;
                r1 = cur_row.r1;
            end
            if (n > 0)
                name_results_due.push_back(r0);
            if (n > 1)
                name_results_due.push_back(r1);
        end
    end

    // ------------------------------------------------------------------------
    // Output side: check every result against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic flag_error(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        idsc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (name_results_due.size() == 0)
                flag_error($sformatf("unexpected result kind=%0d byte=%02h",
                                     result_kind, name_byte));
            else
            begin
                want = name_results_due.pop_front();
                if (result_kind !== want.kind)
                    flag_error($sformatf("result_kind expected %0d got %0d",
                                         want.kind, result_kind));
                if (name_byte !== want.data)
                    flag_error($sformatf("name_byte expected %02h got %02h",
                                         want.data, name_byte));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: random stall per result, stall-free bursts, long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int wait_cycles;
        int taken;
        bit burst_out;
        taken = 0;
        burst_out = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (taken % 60 == 0)
                burst_out = ($urandom_range(0, 3) == 0);
            wait_cycles = burst_out ? 0 : $urandom_range(0, 15);
            if (wait_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            // Hold off while the pressure window is open
            while (long_hold)
            begin
                out_stall <= 1'b1;
                @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // Stop taking results for a long stretch so the result queue fills up
    // and the scanner has to stall its input while the sender keeps offering
    initial
    begin : pressure_window
        wait (taken_bytes >= 300);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Main sequence: build stimulus, reset, drive items, drain, report
    // ------------------------------------------------------------------------
    initial
    begin : byte_source
        int idx;
        int gap;
        bit burst_in;
        burst_in = 1'b0;
        cur_row = DIRECTED_ROWS[0];

        // Walk the table, then append random constructs
        foreach (DIRECTED_ROWS[i])
            source_bytes.push_back(DIRECTED_ROWS[i]);
        while (counted_bytes < RANDOM_ITEMS)
            add_segment();

        // Hold reset, then release it on a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (idx = 0; idx < source_bytes.size(); idx++)
        begin
            if (idx % 60 == 0)
                burst_in = ($urandom_range(0, 3) == 0);
            gap = burst_in ? 0 : $urandom_range(0, 15);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            // Present the item and hold it until the scanner takes it
            cur_row = source_bytes[idx];
            in_valid <= 1'b1;
            data_byte <= cur_row.data;
            end_of_buffer <= cur_row.eob;
            do @(posedge clk); while (in_stall);
            @(negedge clk);
        end
        in_valid <= 1'b0;

        // Drain: every expectation must arrive, then nothing extra may follow
        while (name_results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
